>>> src/hcr_pkg.sv
// Shared constants and types for the Harris corner response block.
`timescale 1ns / 1ps
package hcr_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int LINE_SLOTS = 6;
  localparam int MEM_DEPTH  = LINE_SLOTS * MAX_WIDTH;
  localparam int ADDR_W     = 13;

  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_HARRIS_K     = 2'd2;

  localparam logic signed [47:0] R_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] R_MIN = 48'sh8000_0000_0000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RUN,
    ST_FLUSH,
    ST_MUL1,
    ST_MUL2,
    ST_FIN1,
    ST_FIN2,
    ST_OUT
  } state_t;

endpackage

>>> src/harris_corner_response.sv
// Top level: streaming Harris corner response over a line-buffer memory.
`timescale 1ns / 1ps
// Usage
//   Input channel (in_valid/in_ready): one beat carries a pixel in raster
//   order, or a drain beat (drain=1) that only pushes pending results out
//   once the frame has been fully received.
//   Output channel (out_valid/out_ready): one beat per pixel, raster order,
//   with row, col, last and the running frame min/max.
//   Config port: cfg_write with cfg_index 0 width, 1 height, 2 k (Q0.16).
//   A width or height write restarts the frame.
// Timing
//   A beat that yields no result goes from CHECK back to IDLE. A beat that yields a
//   result passes RUN, FLUSH, MUL1, MUL2, FIN1, FIN2 and OUT: the 3x3 gradients of
//   the 3x3 window are formed from 81 reads of the single-read-port pixel line
//   memory, one per cycle, followed by a short multiply pipeline.
//   The result sits in an output register; the next input beat is taken
//   while it waits. If the receiver stalls, a finished result waits in the
//   OUT state until the register frees.
// Reset
//   Counters and the running min/max clear; config returns to 640x480,
//   k = 2621. The line memory is not cleared and needs no clearing.
module harris_corner_response (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          pixel,
  input  logic                drain,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [47:0]  response,
  output logic [11:0]         row,
  output logic [9:0]          col,
  output logic                last,
  output logic signed [47:0]  frame_min,
  output logic signed [47:0]  frame_max,
  input  logic                cfg_write,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  hcr_pkg::state_t state, state_next;

  logic [10:0] frame_width;
  logic [11:0] frame_height;
  logic [15:0] harris_k;
  logic [10:0] weff;
  logic [11:0] heff;
  logic [21:0] total;
  logic [11:0] lag2;

  logic [11:0] in_row;
  logic [9:0]  in_col;
  logic [2:0]  in_slot;
  logic [21:0] recv;
  logic [21:0] pos;
  logic [11:0] out_row;
  logic [9:0]  out_col;
  logic [2:0]  out_slot;
  logic signed [47:0] running_min, running_max;

  logic [1:0] wy, wx, ty, tx;
  logic [1:0] flush_cnt;

  logic [7:0] mem [0:hcr_pkg::MEM_DEPTH-1];
  logic [7:0] mem_q;
  logic       wr_en;
  logic [hcr_pkg::ADDR_W-1:0] wr_addr, rd_addr;

  logic b_valid, b_inb, b_last, b_win;
  logic [1:0] b_tx, b_ty;
  logic signed [10:0] gx_acc, gy_acc, cx, cy, gx_f, gy_f;
  logic g_valid, g_win;
  logic p_valid;
  logic [21:0] pxx, pyy;
  logic signed [21:0] pxy;
  logic [22:0] sxx, syy;
  logic signed [23:0] sxy;

  logic [45:0] det_a;
  logic [46:0] det_b;
  logic [47:0] tr2;
  logic signed [47:0] det;
  logic [47:0] kt_hi;
  logic [31:0] kt_lo;
  logic [48:0] kt;
  logic signed [47:0] rv;
  logic signed [49:0] rv_wide;
  logic signed [47:0] resp_hold;

  logic accept, take_pixel, issue_last, tap_last;
  logic [22:0] need;
  logic result_ready;
  logic [13:0] yo, wo;
  logic [11:0] xo, wco;
  logic [3:0]  slot_sum;
  logic [2:0]  rd_slot;
  logic [9:0]  rd_x;
  logic        pix_in, win_in;
  logic [23:0] tr;
  logic        out_load, last_now;
  logic signed [47:0] min_new, max_new;

  // effective geometry
  always_comb begin
    if (frame_width < 11'd3) weff = 11'd3;
    else if (frame_width > 11'(hcr_pkg::MAX_WIDTH)) weff = 11'(hcr_pkg::MAX_WIDTH);
    else weff = frame_width;
    heff = (frame_height < 12'd3) ? 12'd3 : frame_height;
  end

  always_ff @(posedge clk) begin
    total <= 22'(weff * heff);
    lag2  <= {weff, 1'b0} + 12'd3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= 11'd640;
      frame_height <= 12'd480;
      harris_k     <= 16'd2621;
    end else if (cfg_write) begin
      case (cfg_index)
        hcr_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data[10:0];
        hcr_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data[11:0];
        hcr_pkg::REG_HARRIS_K:     harris_k     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ready   = (state == hcr_pkg::ST_IDLE);
  assign accept     = in_valid && in_ready;
  assign take_pixel = accept && !drain && (in_row < heff);
  assign tap_last   = (tx == 2'd2) && (ty == 2'd2);
  assign issue_last = tap_last && (wx == 2'd2) && (wy == 2'd2);
  assign out_load   = (state == hcr_pkg::ST_OUT) && (!out_valid || out_ready);
  assign last_now   = ((pos + 22'd1) == total);

  always_comb begin
    need = {1'b0, pos} + {11'd0, lag2};
    if (need > {1'b0, total}) need = {1'b0, total};
    result_ready = ({1'b0, recv} >= need);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= hcr_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      hcr_pkg::ST_IDLE:  if (accept) state_next = hcr_pkg::ST_CHECK;
      hcr_pkg::ST_CHECK: state_next = result_ready ? hcr_pkg::ST_RUN : hcr_pkg::ST_IDLE;
      hcr_pkg::ST_RUN:   if (issue_last) state_next = hcr_pkg::ST_FLUSH;
      hcr_pkg::ST_FLUSH: if (flush_cnt == 2'd2) state_next = hcr_pkg::ST_MUL1;
      hcr_pkg::ST_MUL1:  state_next = hcr_pkg::ST_MUL2;
      hcr_pkg::ST_MUL2:  state_next = hcr_pkg::ST_FIN1;
      hcr_pkg::ST_FIN1:  state_next = hcr_pkg::ST_FIN2;
      hcr_pkg::ST_FIN2:  state_next = hcr_pkg::ST_OUT;
      hcr_pkg::ST_OUT:   if (out_load) state_next = hcr_pkg::ST_IDLE;
      default:           state_next = hcr_pkg::ST_IDLE;
    endcase
  end

  // frame counters
  always_ff @(posedge clk) begin
    if (rst || (cfg_write && (cfg_index == hcr_pkg::REG_FRAME_WIDTH ||
                              cfg_index == hcr_pkg::REG_FRAME_HEIGHT))
        || (out_load && last_now)) begin
      in_row      <= '0;
      in_col      <= '0;
      in_slot     <= '0;
      recv        <= '0;
      pos         <= '0;
      out_row     <= '0;
      out_col     <= '0;
      out_slot    <= '0;
      running_min <= hcr_pkg::R_MAX;
      running_max <= hcr_pkg::R_MIN;
    end else begin
      if (take_pixel) begin
        recv <= recv + 22'd1;
        if ({1'b0, in_col} + 11'd1 >= weff) begin
          in_col  <= '0;
          in_row  <= in_row + 12'd1;
          in_slot <= (in_slot == 3'(hcr_pkg::LINE_SLOTS - 1)) ? 3'd0 : in_slot + 3'd1;
        end else begin
          in_col <= in_col + 10'd1;
        end
      end
      if (out_load) begin
        running_min <= min_new;
        running_max <= max_new;
        pos <= pos + 22'd1;
        if ({1'b0, out_col} + 11'd1 >= weff) begin
          out_col  <= '0;
          out_row  <= out_row + 12'd1;
          out_slot <= (out_slot == 3'(hcr_pkg::LINE_SLOTS - 1)) ? 3'd0 : out_slot + 3'd1;
        end else begin
          out_col <= out_col + 10'd1;
        end
      end
    end
  end

  // line memory
  assign wr_en   = take_pixel;
  assign wr_addr = {in_slot, in_col};

  always_comb begin
    yo  = {2'd0, out_row} + {12'd0, wy} + {12'd0, ty};
    wo  = {2'd0, out_row} + {12'd0, wy};
    xo  = {2'd0, out_col} + {10'd0, wx} + {10'd0, tx};
    wco = {2'd0, out_col} + {10'd0, wx};
    pix_in = (yo >= 14'd2) && (yo < {2'd0, heff} + 14'd2) &&
             (xo >= 12'd2) && (xo < {1'b0, weff} + 12'd2);
    win_in = (wo >= 14'd1) && (wo < {2'd0, heff} + 14'd1) &&
             (wco >= 12'd1) && (wco < {1'b0, weff} + 12'd1);
    slot_sum = {1'b0, out_slot} + {2'd0, wy} + {2'd0, ty} + 4'd4;
    if (slot_sum >= 4'd12) rd_slot = 3'(slot_sum - 4'd12);
    else if (slot_sum >= 4'd6) rd_slot = 3'(slot_sum - 4'd6);
    else rd_slot = slot_sum[2:0];
    rd_x    = 10'(xo - 12'd2);
    rd_addr = {rd_slot, rd_x};
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= pixel;
    if (state == hcr_pkg::ST_RUN) mem_q <= mem[rd_addr];
  end

  // tap sequencer
  always_ff @(posedge clk) begin
    if (state == hcr_pkg::ST_CHECK) begin
      wy <= '0; wx <= '0; ty <= '0; tx <= '0;
    end else if (state == hcr_pkg::ST_RUN) begin
      if (tx == 2'd2) begin
        tx <= '0;
        if (ty == 2'd2) begin
          ty <= '0;
          if (wx == 2'd2) begin
            wx <= '0;
            wy <= wy + 2'd1;
          end else begin
            wx <= wx + 2'd1;
          end
        end else begin
          ty <= ty + 2'd1;
        end
      end else begin
        tx <= tx + 2'd1;
      end
    end
    flush_cnt <= (state == hcr_pkg::ST_FLUSH) ? flush_cnt + 2'd1 : 2'd0;
  end

  // gradient and window-sum pipeline
  always_comb begin
    cx = '0;
    cy = '0;
    if (b_inb) begin
      if (b_tx == 2'd0) cx = -$signed({3'd0, mem_q});
      else if (b_tx == 2'd2) cx = $signed({3'd0, mem_q});
      if (b_ty == 2'd0) cy = -$signed({3'd0, mem_q});
      else if (b_ty == 2'd2) cy = $signed({3'd0, mem_q});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      g_valid <= 1'b0;
      p_valid <= 1'b0;
    end else begin
      b_valid <= (state == hcr_pkg::ST_RUN);
      g_valid <= b_valid && b_last;
      p_valid <= g_valid && g_win;
    end
    b_inb  <= pix_in;
    b_last <= tap_last;
    b_win  <= win_in;
    b_tx   <= tx;
    b_ty   <= ty;
    if (state == hcr_pkg::ST_CHECK) begin
      gx_acc <= '0;
      gy_acc <= '0;
      sxx <= '0;
      syy <= '0;
      sxy <= '0;
    end else begin
      if (b_valid) begin
        if (b_last) begin
          gx_acc <= '0;
          gy_acc <= '0;
        end else begin
          gx_acc <= gx_acc + cx;
          gy_acc <= gy_acc + cy;
        end
      end
      if (p_valid) begin
        sxx <= sxx + {1'b0, pxx};
        syy <= syy + {1'b0, pyy};
        sxy <= sxy + 24'(pxy);
      end
    end
    gx_f  <= gx_acc + cx;
    gy_f  <= gy_acc + cy;
    g_win <= b_win;
    pxx   <= 22'(gx_f * gx_f);
    pyy   <= 22'(gy_f * gy_f);
    pxy   <= 22'(gx_f * gy_f);
  end

  // response arithmetic
  assign tr = {1'b0, sxx} + {1'b0, syy};

  always_comb begin
    rv_wide = {{2{det[47]}}, det} - $signed({1'b0, kt});
    if (rv_wide > $signed({{2{1'b0}}, hcr_pkg::R_MAX})) rv = hcr_pkg::R_MAX;
    else if (rv_wide < $signed({{2{1'b1}}, hcr_pkg::R_MIN})) rv = hcr_pkg::R_MIN;
    else rv = rv_wide[47:0];
  end

  always_ff @(posedge clk) begin
    if (state == hcr_pkg::ST_MUL1) begin
      det_a <= sxx * syy;
      det_b <= 47'(sxy * sxy);
      tr2   <= tr * tr;
    end
    if (state == hcr_pkg::ST_MUL2) begin
      det   <= $signed({2'd0, det_a}) - $signed({1'b0, det_b});
      kt_hi <= tr2[47:16] * harris_k;
      kt_lo <= tr2[15:0] * harris_k;
    end
    if (state == hcr_pkg::ST_FIN1) begin
      kt <= {1'b0, kt_hi} + 49'((33'(kt_lo) + 33'd32768) >> 16);
    end
    if (state == hcr_pkg::ST_FIN2) begin
      resp_hold <= rv;
    end
  end

  assign min_new = (resp_hold < running_min) ? resp_hold : running_min;
  assign max_new = (resp_hold > running_max) ? resp_hold : running_max;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      response  <= resp_hold;
      row       <= out_row;
      col       <= out_col;
      last      <= last_now;
      frame_min <= min_new;
      frame_max <= max_new;
    end
  end

endmodule
